[src/echo_distance_burst_averager_defines.svh]
`ifndef ECHO_DISTANCE_BURST_AVERAGER_DEFINES_SVH
`define ECHO_DISTANCE_BURST_AVERAGER_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define EDBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is held.
`define EDBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/edba_pkg.sv]
`timescale 1ns / 1ps

package edba_pkg;

  localparam int MAX_BURST_DEF         = 8;
  localparam int LEVEL_SAMPLE_BITS_DEF = 12;

  localparam int ECHO_W     = 15;
  localparam int LEVEL_W    = 12;
  localparam int DIST_W     = 16;
  localparam int SUM_W      = 19;
  localparam int FS_W       = 9;
  localparam int BL_W       = 4;
  localparam int NUM_W      = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int ECHO_PROD_W = ECHO_W + 11;
  localparam int ECHO_SHIFT  = 10;

  localparam int IN_TDATA_W  = ((ECHO_W + LEVEL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  localparam logic [10:0]        ECHO_FACTOR = 11'd1756;
  localparam logic [6:0]         CENTI       = 7'd100;
  localparam logic [LEVEL_W-1:0] HEALTH_LOW  = 12'd10;
  localparam logic [LEVEL_W-1:0] HEALTH_HIGH = 12'd4080;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_PRESENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FS_CM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_CM   = 3'd4;

  typedef enum logic [1:0] {
    SRC_ECHO  = 2'd0,
    SRC_LEVEL = 2'd1,
    SRC_NONE  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACC,
    ST_LMUL,
    ST_LSCALE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            echo_mode;
    logic            level_present;
    logic [BL_W-1:0] burst_length;
    logic [FS_W-1:0] level_fs_cm;
    logic [FS_W-1:0] max_dist_cm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    echo_mode:     1'b1,
    level_present: 1'b1,
    burst_length:  4'd5,
    level_fs_cm:   9'd300,
    max_dist_cm:   9'd400
  };

endpackage

[src/echo_distance_burst_averager.sv]
`timescale 1ns / 1ps
// Requests are handled one at a time, each to the end before the next is taken. A
// request that closes an echo burst, or a level-mode request, runs through the
// 28-step bit-serial divider (the level sample first passes ST_LMUL and ST_LSCALE);
// a request that does not close a burst, or has no valid reading, skips the divider.
// A stalled output holds the sequencer in ST_DONE until the result is taken.
// Reset is asynchronous, active low, and restores register defaults and an empty burst.

module echo_distance_burst_averager import edba_pkg::*; #(
  parameter int MAX_BURST         = MAX_BURST_DEF,
  parameter int LEVEL_SAMPLE_BITS = LEVEL_SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // echo_time_us [14:0], level_sample [26:15], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // distance_centi_cm [15:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // source_code [1:0], sensor_healthy [2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int CNT_W   = $clog2(MAX_BURST + 1);
  localparam int LVL_W   = (LEVEL_SAMPLE_BITS < LEVEL_W) ? LEVEL_SAMPLE_BITS : LEVEL_W;
  localparam int DEN_W   = (LEVEL_SAMPLE_BITS > CNT_W) ? LEVEL_SAMPLE_BITS : CNT_W;
  localparam int FULL    = (1 << LEVEL_SAMPLE_BITS) - 1;
  localparam int LPROD_W = LVL_W + FS_W;

  cfg_t cfg;

  state_e state_d, state_q;

  logic [ECHO_W-1:0]  echo_q;
  logic [LEVEL_W-1:0] level_q;
  logic [DIST_W-1:0]  d_q;
  logic [CNT_W-1:0]   pos_d, pos_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [SUM_W-1:0]   sum_d, sum_q;
  src_e               src_q;
  logic               healthy_q;
  logic [LPROD_W-1:0] lprod_q;
  logic               out_valid_d, out_valid_q;
  logic [DIST_W-1:0]  out_dist_q;
  src_e               out_src_q;
  logic               out_healthy_q;

  logic [DIST_W-1:0]      limit;
  logic [ECHO_PROD_W-1:0] echo_prod;
  logic                   echo_ok;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_acc;
  logic [CNT_W-1:0]       cnt_acc;
  logic [CNT_W-1:0]       pos_inc;
  logic [CNT_W-1:0]       eff_burst;
  logic                   burst_end;
  logic                   lvl_healthy;
  logic [NUM_W-1:0]       lscale;
  logic [DIST_W-1:0]      dist_final;

  logic             div_start;
  logic             div_sel_level;
  logic             div_busy;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic             out_load;

  edba_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  edba_div #(
    .N_W (NUM_W),
    .D_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------
  // Datapath arithmetic
  // ---------------------------------------------------------------------
  assign limit     = {7'd0, cfg.max_dist_cm} * {9'd0, CENTI};
  assign echo_prod = {11'd0, echo_q} * {{(ECHO_PROD_W-11){1'b0}}, ECHO_FACTOR};
  assign echo_ok   = (d_q != '0) && (d_q < limit);
  assign sum_ext   = {1'b0, sum_q} + {{(SUM_W+1-DIST_W){1'b0}}, d_q};
  assign sum_acc   = !echo_ok ? sum_q : (sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0]);
  assign cnt_acc   = cnt_q + CNT_W'(echo_ok);
  assign pos_inc   = pos_q + 1'b1;

  // A burst length of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (cfg.burst_length == '0) begin
      eff_burst = CNT_W'(1);
    end else if (32'(cfg.burst_length) > 32'(MAX_BURST)) begin
      eff_burst = CNT_W'(MAX_BURST);
    end else begin
      eff_burst = CNT_W'(cfg.burst_length);
    end
  end

  assign burst_end   = pos_inc >= eff_burst;
  assign lvl_healthy = (level_q > HEALTH_LOW) && (level_q < HEALTH_HIGH);
  assign lscale      = NUM_W'(lprod_q) * NUM_W'(CENTI);

  assign div_num = div_sel_level ? lscale : NUM_W'(sum_acc);
  assign div_den = div_sel_level ? DEN_W'(FULL) : DEN_W'(cnt_acc);

  always_comb begin
    if (src_q == SRC_NONE) begin
      dist_final = '0;
    end else if (div_quot > NUM_W'(limit)) begin
      dist_final = limit;
    end else begin
      dist_final = div_quot[DIST_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (cfg.echo_mode) begin
          state_d = ST_ACC;
        end else if (cfg.level_present) begin
          state_d = ST_LMUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ACC: begin
        if (!burst_end) begin
          state_d = ST_IDLE;
        end else if (cnt_acc != '0) begin
          state_d = ST_DIV;
        end else if (cfg.level_present) begin
          state_d = ST_LMUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LMUL:   state_d = ST_LSCALE;
      ST_LSCALE: state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_sel_level = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_ACC:    div_start = burst_end && (cnt_acc != '0);
      ST_LSCALE: begin
        div_start     = 1'b1;
        div_sel_level = 1'b1;
      end
      ST_DONE:   out_load = !out_valid_q || m_axis_tready;
      ST_EVAL, ST_LMUL, ST_DIV: ;
      default: ;
    endcase
  end

  // Burst bookkeeping: level-mode requests and closing requests empty the burst.
  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    sum_d = sum_q;
    if ((state_q == ST_EVAL && !cfg.echo_mode) || (state_q == ST_ACC && burst_end)) begin
      pos_d = '0;
      cnt_d = '0;
      sum_d = '0;
    end else if (state_q == ST_ACC) begin
      pos_d = pos_inc;
      cnt_d = cnt_acc;
      sum_d = sum_acc;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      echo_q  <= s_axis_tdata[ECHO_W-1:0];
      level_q <= s_axis_tdata[ECHO_W +: LEVEL_W];
    end
    if (state_q == ST_EVAL) begin
      d_q <= echo_prod[ECHO_SHIFT +: DIST_W];
      if (!cfg.echo_mode) begin
        src_q     <= cfg.level_present ? SRC_LEVEL : SRC_NONE;
        healthy_q <= cfg.level_present && lvl_healthy;
      end
    end
    if (state_q == ST_ACC && burst_end) begin
      healthy_q <= echo_ok;
      if (cnt_acc != '0) begin
        src_q <= SRC_ECHO;
      end else begin
        src_q <= cfg.level_present ? SRC_LEVEL : SRC_NONE;
      end
    end
    if (state_q == ST_LMUL) begin
      lprod_q <= LPROD_W'(level_q[LVL_W-1:0]) * LPROD_W'(cfg.level_fs_cm);
    end
    if (out_load) begin
      out_dist_q    <= dist_final;
      out_src_q     <= src_q;
      out_healthy_q <= healthy_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_dist_q);
  assign m_axis_tuser  = {out_healthy_q, out_src_q};

endmodule

[src/edba_cfg.sv]
`timescale 1ns / 1ps

module edba_cfg import edba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ECHO_MODE:     cfg_d.echo_mode     = cfg_data_i[0];
        REG_LEVEL_PRESENT: cfg_d.level_present = cfg_data_i[0];
        REG_BURST_LENGTH:  cfg_d.burst_length  = cfg_data_i[BL_W-1:0];
        REG_LEVEL_FS_CM:   cfg_d.level_fs_cm   = cfg_data_i[FS_W-1:0];
        REG_MAX_DIST_CM:   cfg_d.max_dist_cm   = cfg_data_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/edba_div.sv]
`timescale 1ns / 1ps

module edba_div import edba_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           busy_o,
  output logic [N_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [N_W-1:0]   acc_d, acc_q;
  logic [D_W-1:0]   rem_d, rem_q;
  logic [D_W-1:0]   den_d, den_q;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  // Restoring division: the dividend shifts out of acc_q at the top while
  // quotient bits shift in at the bottom, one bit per cycle.
  assign trial = {rem_q, acc_q[N_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(N_W);
      acc_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      acc_d = {acc_q[N_W-2:0], fits};
      rem_d = fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = acc_q;

endmodule

[src/edba_checker.sv]
`timescale 1ns / 1ps
`include "echo_distance_burst_averager_defines.svh"

module edba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result keeps its payload.
  `EDBA_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // The sequencer works on one request at a time.
  `EDBA_ASSERT(a_one_request, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

  // Source code three is never produced.
  `EDBA_ASSERT_ALWAYS(a_src_code, clk_i, m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3, "bad source code")

  // With no valid reading the distance is zero and the sensor is not healthy.
  `EDBA_ASSERT(a_none_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1:0] == 2'd2 |-> m_axis_tdata == 16'd0 && !m_axis_tuser[2], "no-reading result not zero")

  // Distances never exceed the largest programmable limit.
  `EDBA_ASSERT(a_dist_limit, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata <= 16'd51100, "distance above limit")

endmodule

bind echo_distance_burst_averager edba_checker u_edba_checker (.*);
